/* hdl/awst_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// awst_pkg
// Shared constants, register codes and the sponge weight table of the
// acoustic wave stencil step core.
// ----------------------------------------------------------------------------
package awst_pkg;

  localparam int ROWS_MAX   = 512;
  localparam int COLS_MAX   = 1024;
  localparam int SPONGE_MAX = 64;
  localparam int FRAC_BITS  = 16;
  localparam int COEF_FRAC  = 24;

  localparam int DATA_W     = 32;
  localparam int ROWS_CFG_W = 10;
  localparam int COLS_CFG_W = 11;
  localparam int SPNG_CFG_W = 7;
  localparam int CFG_IDX_W  = 3;

  localparam int RW    = $clog2(ROWS_MAX);
  localparam int CW    = $clog2(COLS_MAX + 2);
  localparam int PW    = $clog2(((ROWS_MAX > COLS_MAX) ? ROWS_MAX : COLS_MAX) + 3) + 1;
  localparam int IDX_W = (SPONGE_MAX > 1) ? $clog2(SPONGE_MAX) : 1;
  localparam int W_W   = 25;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_COEF_Z_NEAR  = 3'd0,
    REG_COEF_Z_FAR   = 3'd1,
    REG_COEF_X_NEAR  = 3'd2,
    REG_COEF_X_FAR   = 3'd3,
    REG_ROWS_USED    = 3'd4,
    REG_COLS_USED    = 3'd5,
    REG_SPONGE_CELLS = 3'd6
  } cfg_reg_t;

  typedef logic [W_W-1:0] wrom_t [SPONGE_MAX];

  // exp(-(0.015 d)^2) in Q0.24: Taylor series of exp(-x/16), squared four times
  function automatic wrom_t build_rom();
    wrom_t rom;
    longint unsigned t;
    longint unsigned term;
    longint unsigned s;
    longint sum;
    for (int d = 1; d <= SPONGE_MAX; d++) begin
      t = ((64'd225 * 64'(d) * 64'(d)) << 32) / 64'd16000000;
      term = 64'd1 << 32;
      sum = longint'(term);
      for (int k = 1; k <= 20; k++) begin
        term = ((term * t) >> 32) / 64'(k);
        if ((k & 1) != 0) sum = sum - longint'(term);
        else sum = sum + longint'(term);
      end
      if (sum < 0) sum = 0;
      if (sum > longint'(64'hFFFF_FFFF)) sum = longint'(64'hFFFF_FFFF);
      s = 64'(sum);
      for (int k = 0; k < 4; k++) s = (s * s) >> 32;
      rom[d-1] = W_W'((s + 64'd128) >> 8);
    end
    return rom;
  endfunction

  localparam wrom_t WEIGHT_ROM = build_rom();

endpackage

/* hdl/awst_ifs.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// awst_ifs
// Valid/ready channels of the stencil core: grid points in, results out,
// and the register write channel.
// ----------------------------------------------------------------------------
interface awst_in_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [awst_pkg::DATA_W-1:0]    cur_value;
  logic signed [awst_pkg::DATA_W-1:0]    prev_value;
  logic        [awst_pkg::DATA_W-1:0]    vel_term;
  logic                                  flush;
  modport source (output valid, cur_value, prev_value, vel_term, flush, input ready);
  modport sink   (input valid, cur_value, prev_value, vel_term, flush, output ready);
endinterface

interface awst_out_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [awst_pkg::DATA_W-1:0]    next_value;
  logic signed [awst_pkg::DATA_W-1:0]    damped_current;
  logic                                  last_of_frame;
  logic                                  saturated;
  modport source (output valid, next_value, damped_current, last_of_frame, saturated,
                  input ready);
  modport sink   (input valid, next_value, damped_current, last_of_frame, saturated,
                  output ready);
endinterface

interface awst_cfg_if;
  logic                                  valid;
  logic                                  ready;
  logic [awst_pkg::CFG_IDX_W-1:0]        index;
  logic [awst_pkg::DATA_W-1:0]           data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

/* hdl/acoustic_wave_stencil_step_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acoustic_wave_stencil_step_core
// Streaming 4th-order 2-D acoustic wave step with sponge damping.
// ----------------------------------------------------------------------------
// Takes one grid point per clock in column order (depth fastest) and returns
// the point two columns behind; with the result side ready the core sustains
// one point per cycle. The rate is set by the four column RAMs that hold the
// current field: each takes one read and one write per cycle, the z window of
// the center column comes from a small history register, and the prev/vel
// delay RAM is read and rewritten at the same address. A frame spans cols+2
// input columns; the first two columns return no result, so the last two
// input columns of a frame only drain the lag. Memories are not cleared after
// reset, so no clearing pass exists. The user must write registers only while
// the core is idle; the core does not enforce this. The write channel is always ready.
module acoustic_wave_stencil_step_core (
  input  logic       clk,
  input  logic       rst,
  awst_in_if.sink    samples,
  awst_out_if.source results,
  awst_cfg_if.sink   cfg
);

  localparam int DW    = awst_pkg::DATA_W;
  localparam int RW    = awst_pkg::RW;
  localparam int CW    = awst_pkg::CW;
  localparam int PW    = awst_pkg::PW;
  localparam int W_W   = awst_pkg::W_W;
  localparam int IDX_W = awst_pkg::IDX_W;
  localparam int SLOTS = 4;
  localparam int TW    = 2 * DW - awst_pkg::COEF_FRAC;  // floored coefficient term
  localparam int SW    = TW + 2;                        // sum of four terms
  localparam int NW    = 51;                            // wide pre-saturation value

  typedef struct packed {
    logic           has_res;
    logic           interior;
    logic           last;
    logic           on_b;
    logic           on_l;
    logic           on_r;
    logic [W_W-1:0] w_b;
    logic [W_W-1:0] w_l;
    logic [W_W-1:0] w_r;
  } ctl_t;

  function automatic logic signed [TW-1:0] cterm(logic signed [DW-1:0] c,
                                                 logic signed [DW-1:0] p);
    logic signed [2*DW-1:0] prod;
    prod = c * p;
    return prod[2*DW-1:awst_pkg::COEF_FRAC];
  endfunction

  function automatic logic [DW:0] sat32(logic signed [NW-1:0] v);
    logic signed [NW-1:0] hi;
    logic signed [NW-1:0] lo;
    hi = NW'(signed'({1'b0, {(DW-1){1'b1}}}));
    lo = -hi - NW'(1);
    if (v > hi) return {1'b1, 1'b0, {(DW-1){1'b1}}};
    if (v < lo) return {1'b1, 1'b1, {(DW-1){1'b0}}};
    return {1'b0, v[DW-1:0]};
  endfunction

  function automatic logic signed [DW-1:0] damp_step(logic signed [DW-1:0] x, logic on,
                                                     logic [W_W-1:0] w);
    logic signed [DW+W_W:0] prod;
    prod = x * $signed({1'b0, w}) + (DW+W_W+1)'(1 << (awst_pkg::COEF_FRAC - 1));
    return on ? prod[DW+awst_pkg::COEF_FRAC-1:awst_pkg::COEF_FRAC] : x;
  endfunction

  // ---------------- configuration ----------------
  logic signed [DW-1:0]                   coef_z_near, coef_z_far, coef_x_near, coef_x_far;
  logic [awst_pkg::ROWS_CFG_W-1:0]        rows_cfg;
  logic [awst_pkg::COLS_CFG_W-1:0]        cols_cfg;
  logic [awst_pkg::SPNG_CFG_W-1:0]        sponge_cfg;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      coef_z_near <= '0;
      coef_z_far  <= '0;
      coef_x_near <= '0;
      coef_x_far  <= '0;
      rows_cfg    <= awst_pkg::ROWS_CFG_W'(5);
      cols_cfg    <= awst_pkg::COLS_CFG_W'(5);
      sponge_cfg  <= '0;
    end else if (cfg.valid) begin
      case (cfg.index)
        awst_pkg::REG_COEF_Z_NEAR:  coef_z_near <= cfg.data;
        awst_pkg::REG_COEF_Z_FAR:   coef_z_far  <= cfg.data;
        awst_pkg::REG_COEF_X_NEAR:  coef_x_near <= cfg.data;
        awst_pkg::REG_COEF_X_FAR:   coef_x_far  <= cfg.data;
        awst_pkg::REG_ROWS_USED:    rows_cfg    <= cfg.data[awst_pkg::ROWS_CFG_W-1:0];
        awst_pkg::REG_COLS_USED:    cols_cfg    <= cfg.data[awst_pkg::COLS_CFG_W-1:0];
        awst_pkg::REG_SPONGE_CELLS: sponge_cfg  <= cfg.data[awst_pkg::SPNG_CFG_W-1:0];
        default: ;
      endcase
    end
  end

  logic [PW-1:0] rows_p, cols_p, nb_p;
  always_comb begin
    rows_p = (rows_cfg < awst_pkg::ROWS_CFG_W'(5)) ? PW'(5) :
             (32'(rows_cfg) > awst_pkg::ROWS_MAX) ? PW'(awst_pkg::ROWS_MAX) : PW'(rows_cfg);
    cols_p = (cols_cfg < awst_pkg::COLS_CFG_W'(5)) ? PW'(5) :
             (32'(cols_cfg) > awst_pkg::COLS_MAX) ? PW'(awst_pkg::COLS_MAX) : PW'(cols_cfg);
    nb_p   = (32'(sponge_cfg) > awst_pkg::SPONGE_MAX) ? PW'(awst_pkg::SPONGE_MAX) :
             PW'(sponge_cfg);
  end

  // ---------------- pipeline control ----------------
  logic v1, v8;
  logic adv, accept;
  logic [7:0] vld;

  assign adv           = !results.valid || results.ready;
  assign samples.ready = adv;
  assign accept        = samples.valid && adv;

  // ---------------- position ----------------
  logic [RW-1:0] row_count;
  logic [CW-1:0] col_count;
  logic [PW-1:0] r_p, c_pre, c_p, ox_p, r_inc, c_inc;
  logic [RW-1:0] r0;
  logic [1:0]    c_lo;
  ctl_t          ctl0;
  logic [PW-1:0] ib_b, ib_r;

  always_comb begin
    r_p   = PW'(row_count);
    c_pre = PW'(col_count);
    if (r_p >= rows_p) begin
      r_p   = '0;
      c_pre = c_pre + PW'(1);
    end
    c_p   = (c_pre >= cols_p + PW'(2)) ? '0 : c_pre;
    r0    = r_p[RW-1:0];
    c_lo  = c_p[1:0];
    ox_p  = c_p - PW'(2);
    r_inc = r_p + PW'(1);
    c_inc = c_p + PW'(1);

    ib_b = rows_p - PW'(1) - r_p;
    ib_r = cols_p - PW'(1) - ox_p;
    ctl0.has_res  = (c_p >= PW'(2));
    ctl0.interior = (ox_p >= PW'(2)) && (ox_p + PW'(2) < cols_p) &&
                    (r_p >= PW'(2)) && (r_p + PW'(2) < rows_p);
    ctl0.last     = (ox_p == cols_p - PW'(1)) && (r_p == rows_p - PW'(1));
    ctl0.on_b     = (ib_b < nb_p);
    ctl0.on_l     = (ox_p < nb_p);
    ctl0.on_r     = (ib_r < nb_p);
    ctl0.w_b = awst_pkg::WEIGHT_ROM[IDX_W'(nb_p - PW'(1) - ib_b)];
    ctl0.w_l = awst_pkg::WEIGHT_ROM[IDX_W'(nb_p - PW'(1) - ox_p)];
    ctl0.w_r = awst_pkg::WEIGHT_ROM[IDX_W'(nb_p - PW'(1) - ib_r)];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_count <= '0;
      col_count <= '0;
    end else if (accept) begin
      if (r_inc >= rows_p) begin
        row_count <= '0;
        col_count <= (c_inc >= cols_p + PW'(2)) ? '0 : c_inc[CW-1:0];
      end else begin
        row_count <= r_inc[RW-1:0];
      end
    end
  end

  // flush beats carry zero data
  logic signed [DW-1:0] cur_in, prev_in;
  logic [DW-1:0]        vel_in;
  assign cur_in  = samples.flush ? '0 : samples.cur_value;
  assign prev_in = samples.flush ? '0 : samples.prev_value;
  assign vel_in  = samples.flush ? '0 : samples.vel_term;

  // ---------------- column RAMs ----------------
  // slot roles seen from column c: c (holds c-4), c-1, c-2 (center, read 2 rows ahead), c-3
  logic [DW-1:0] col_rd [SLOTS];

  for (genvar s = 0; s < SLOTS; s++) begin : g_col
    logic [DW-1:0] mem [awst_pkg::ROWS_MAX];
    logic [1:0]    role;
    logic [RW-1:0] raddr;
    always_comb begin
      role  = 2'(s) - c_lo;
      raddr = (role == 2'd2) ? r0 + RW'(2) : r0;
    end
    always_ff @(posedge clk) begin
      if (adv) col_rd[s] <= mem[raddr];
      if (accept && c_lo == 2'(s)) mem[r0] <= cur_in;
    end
  end

  // rows 0 and 1 of each column, for the top of the z window
  logic [DW-1:0] head [SLOTS][2];
  logic [1:0]    ctr_slot;
  assign ctr_slot = c_lo - 2'd2;

  always_ff @(posedge clk) begin
    if (accept && r_p < PW'(2)) head[c_lo][r0[0]] <= cur_in;
  end

  // ---------------- prev / vel delay RAM ----------------
  logic [DW-1:0] prev_mem [2*awst_pkg::ROWS_MAX];
  logic [DW-1:0] vel_mem  [2*awst_pkg::ROWS_MAX];
  logic [RW:0]   dly_addr;
  logic [DW-1:0] prev_rd, vel_rd;
  assign dly_addr = {c_p[0], r0};

  always_ff @(posedge clk) begin
    if (adv) begin
      prev_rd <= prev_mem[dly_addr];
      vel_rd  <= vel_mem[dly_addr];
    end
    if (accept) begin
      prev_mem[dly_addr] <= prev_in;
      vel_mem[dly_addr]  <= vel_in;
    end
  end

  // ---------------- stage 1: operand fetch ----------------
  ctl_t                 ctl1;
  logic signed [DW-1:0] cur1, h0_1, h1_1;
  logic [1:0]           clo1;
  logic [RW-1:0]        r1;
  logic [DW-1:0]        hist [4];

  always_ff @(posedge clk) begin
    if (adv) begin
      ctl1 <= ctl0;
      cur1 <= cur_in;
      h0_1 <= head[ctr_slot][0];
      h1_1 <= head[ctr_slot][1];
      clo1 <= c_lo;
      r1   <= r0;
    end
  end

  logic signed [DW-1:0] xf1, xm1, zf1, xp1, ctr1, zm1, zm2, zp1;
  always_comb begin
    xf1  = col_rd[clo1];
    xm1  = col_rd[clo1 + 2'd1];
    zf1  = col_rd[clo1 + 2'd2];
    xp1  = col_rd[clo1 + 2'd3];
    ctr1 = (r1 == RW'(0)) ? h0_1 : (r1 == RW'(1)) ? h1_1 : hist[1];
    zm1  = (r1 == RW'(1)) ? h0_1 : (r1 == RW'(2)) ? h1_1 : hist[2];
    zm2  = (r1 == RW'(2)) ? h0_1 : (r1 == RW'(3)) ? h1_1 : hist[3];
    zp1  = hist[0];
  end

  always_ff @(posedge clk) begin
    if (adv && v1) begin
      hist[0] <= zf1;
      hist[1] <= hist[0];
      hist[2] <= hist[1];
      hist[3] <= hist[2];
    end
  end

  // ---------------- stage 2: coefficient products ----------------
  ctl_t                 ctl2;
  logic signed [TW-1:0] tz [4];
  logic signed [TW-1:0] tx [4];
  logic signed [TW-1:0] tc [4];
  logic signed [DW-1:0] ctr2, p2;
  logic [DW-1:0]        vel2;

  always_ff @(posedge clk) begin
    if (adv) begin
      ctl2  <= ctl1;
      tz[0] <= cterm(coef_z_near, zm1);
      tz[1] <= cterm(coef_z_near, zp1);
      tz[2] <= cterm(coef_z_far, zm2);
      tz[3] <= cterm(coef_z_far, zf1);
      tx[0] <= cterm(coef_x_near, xm1);
      tx[1] <= cterm(coef_x_near, xp1);
      tx[2] <= cterm(coef_x_far, xf1);
      tx[3] <= cterm(coef_x_far, cur1);
      tc[0] <= cterm(coef_z_near, ctr1);
      tc[1] <= cterm(coef_z_far, ctr1);
      tc[2] <= cterm(coef_x_near, ctr1);
      tc[3] <= cterm(coef_x_far, ctr1);
      ctr2  <= ctr1;
      p2    <= prev_rd;
      vel2  <= vel_rd;
    end
  end

  // ---------------- stage 3: partial sums ----------------
  ctl_t                 ctl3;
  logic signed [SW-1:0] zs3, xs3, cs3;
  logic signed [DW-1:0] ctr3, p3;
  logic [DW-1:0]        vel3;

  always_ff @(posedge clk) begin
    if (adv) begin
      ctl3 <= ctl2;
      zs3  <= SW'(tz[0]) + SW'(tz[1]) + SW'(tz[2]) + SW'(tz[3]);
      xs3  <= SW'(tx[0]) + SW'(tx[1]) + SW'(tx[2]) + SW'(tx[3]);
      cs3  <= SW'(tc[0]) + SW'(tc[1]) + SW'(tc[2]) + SW'(tc[3]);
      ctr3 <= ctr2;
      p3   <= p2;
      vel3 <= vel2;
    end
  end

  // ---------------- stage 4: laplacian ----------------
  ctl_t                 ctl4;
  logic signed [DW-1:0] lap4, ctr4, p4;
  logic                 sat4;
  logic [DW-1:0]        vel4;
  logic [DW:0]          lap_s;

  assign lap_s = sat32(NW'(zs3) + NW'(xs3) - (NW'(cs3) <<< 1));

  always_ff @(posedge clk) begin
    if (adv) begin
      ctl4 <= ctl3;
      lap4 <= lap_s[DW-1:0];
      sat4 <= lap_s[DW];
      ctr4 <= ctr3;
      p4   <= p3;
      vel4 <= vel3;
    end
  end

  // ---------------- stage 5: velocity product ----------------
  ctl_t                 ctl5;
  logic signed [2*DW:0] vp5;
  logic signed [DW-1:0] ctr5, p5;
  logic                 sat5;

  always_ff @(posedge clk) begin
    if (adv) begin
      ctl5 <= ctl4;
      vp5  <= $signed({1'b0, vel4}) * lap4;
      ctr5 <= ctr4;
      p5   <= p4;
      sat5 <= sat4;
    end
  end

  // ---------------- stage 6: leapfrog update ----------------
  ctl_t                 ctl6;
  logic signed [DW-1:0] nx6, cd6;
  logic                 sat6;
  logic [DW:0]          nx_s;
  logic signed [2*DW:0] vp_sh;

  always_comb begin
    vp_sh = vp5 >>> awst_pkg::FRAC_BITS;
    nx_s  = sat32((NW'(ctr5) <<< 1) - NW'(p5) + NW'(vp_sh));
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ctl6 <= ctl5;
      nx6  <= ctl5.interior ? nx_s[DW-1:0] : p5;
      sat6 <= ctl5.interior && (sat5 || nx_s[DW]);
      cd6  <= ctr5;
    end
  end

  // ---------------- stages 7..9: sponge, bottom then left then right ----------------
  ctl_t                 ctl7, ctl8;
  logic signed [DW-1:0] nx7, cd7, nx8, cd8;
  logic                 sat7, sat8;

  always_ff @(posedge clk) begin
    if (adv) begin
      ctl7 <= ctl6;
      nx7  <= damp_step(nx6, ctl6.on_b, ctl6.w_b);
      cd7  <= damp_step(cd6, ctl6.on_b, ctl6.w_b);
      sat7 <= sat6;
      ctl8 <= ctl7;
      nx8  <= damp_step(nx7, ctl7.on_l, ctl7.w_l);
      cd8  <= damp_step(cd7, ctl7.on_l, ctl7.w_l);
      sat8 <= sat7;
      results.next_value     <= damp_step(nx8, ctl8.on_r, ctl8.w_r);
      results.damped_current <= damp_step(cd8, ctl8.on_r, ctl8.w_r);
      results.last_of_frame  <= ctl8.last;
      results.saturated      <= sat8;
    end
  end

  // beat valids; items of the first two columns travel but raise no result
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[6:0], accept};
    end
  end

  assign v1 = vld[0];
  assign v8 = vld[7];

  logic has9;
  always_ff @(posedge clk) begin
    if (rst) begin
      has9 <= 1'b0;
    end else if (adv) begin
      has9 <= v8 && ctl8.has_res;
    end
  end

  assign results.valid = has9;

endmodule

/* hdl/awst_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// awst_checker
// Port-level checks of the stencil core, bound to the top level.
// ----------------------------------------------------------------------------
module awst_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [awst_pkg::DATA_W-1:0]   out_next,
  input logic [awst_pkg::DATA_W-1:0]   out_damped,
  input logic                          cfg_ready
);

  // a waiting result beat is held
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_next) && $stable(out_damped))
    else $error("result beat dropped or changed while stalled");

  // nothing comes out right after reset
  a_rst_quiet: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  // input side only waits while a result stalls
  a_in_ready: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled without a stalled result");

  a_cfg_ready: assert property (@(posedge clk) disable iff (rst) cfg_ready)
    else $error("register channel not ready");

endmodule

bind acoustic_wave_stencil_step_core awst_checker u_awst_checker (
  .clk        (clk),
  .rst        (rst),
  .in_ready   (samples.ready),
  .out_valid  (results.valid),
  .out_ready  (results.ready),
  .out_next   (results.next_value),
  .out_damped (results.damped_current),
  .cfg_ready  (cfg.ready)
);

/* tb/sv/acoustic_wave_stencil_step_core_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acoustic_wave_stencil_step_core_test
// Self-checking bench for the streaming wave stencil step core.
// ----------------------------------------------------------------------------
// Whole frames of grid points stream in under bursty valid and patterned
// ready. A local model of the column buffers, the cross stencil, the leapfrog
// update and the sponge bands predicts each result beat, and the monitor
// compares every beat field by field. Registers change only between frames.
// ----------------------------------------------------------------------------
module acoustic_wave_stencil_step_core_test;

  typedef struct {
    logic [31:0] cur;
    logic [31:0] prev;
    logic [31:0] vel;
    logic        flush;
  } point_t;

  typedef struct {
    logic [31:0] next_val;
    logic [31:0] damped;
    logic        last;
    logic        sat;
  } update_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  awst_in_if  samples_if ();
  awst_out_if results_if ();
  awst_cfg_if cfg_if ();

  acoustic_wave_stencil_step_core dut (
    .clk     (clk),
    .rst     (rst),
    .samples (samples_if),
    .results (results_if),
    .cfg     (cfg_if)
  );

  always #5 clk = ~clk;

  point_t  pending_points [$];
  update_t expected_updates [$];
  bit      failed = 1'b0;

  // register shadow and stream position
  longint      kz_near, kz_far, kx_near, kx_far;
  logic [9:0]  rows_reg;
  logic [10:0] cols_reg;
  logic [6:0]  sponge_reg;
  int          row_pos, col_pos;
  logic [31:0] cur_mem   [4*awst_pkg::ROWS_MAX];
  logic [31:0] prev_line [2*awst_pkg::ROWS_MAX+2];
  logic [31:0] vel_line  [2*awst_pkg::ROWS_MAX+2];

  function automatic int rows_eff();
    return (rows_reg < 5) ? 5 :
           ((rows_reg > awst_pkg::ROWS_MAX) ? awst_pkg::ROWS_MAX : int'(rows_reg));
  endfunction

  function automatic int cols_eff();
    return (cols_reg < 5) ? 5 :
           ((cols_reg > awst_pkg::COLS_MAX) ? awst_pkg::COLS_MAX : int'(cols_reg));
  endfunction

  function automatic longint cur_at(int slot, int row);
    return longint'($signed(cur_mem[(slot % 4) * awst_pkg::ROWS_MAX + row]));
  endfunction

  function automatic longint tap(longint k, longint p);
    return (k * p) >>> awst_pkg::COEF_FRAC;
  endfunction

  function automatic longint clip32(longint v, inout bit flag);
    if (v > 64'sd2147483647) begin
      flag = 1'b1;
      return 64'sd2147483647;
    end
    if (v < -64'sd2147483648) begin
      flag = 1'b1;
      return -64'sd2147483648;
    end
    return v;
  endfunction

  function automatic longint weigh(longint x, int d);
    return (x * longint'(awst_pkg::WEIGHT_ROM[d-1]) + (64'sd1 <<< 23)) >>> awst_pkg::COEF_FRAC;
  endfunction

  // bottom, then left, then right band
  function automatic longint sponge(longint x, int ox, int oz, int rows, int cols, int nb);
    if (rows - 1 - oz < nb) x = weigh(x, nb - (rows - 1 - oz));
    if (ox < nb) x = weigh(x, nb - ox);
    if (cols - 1 - ox < nb) x = weigh(x, nb - (cols - 1 - ox));
    return x;
  endfunction

  function automatic void advance_stencil(point_t p);
    int rows, cols, nb, c, r, dslot, ox, oz;
    longint cur, prev, center, p_old, lap, nxt;
    logic [31:0] vel;
    bit flag;
    update_t u;
    rows = rows_eff();
    cols = cols_eff();
    nb = (sponge_reg > awst_pkg::SPONGE_MAX) ? awst_pkg::SPONGE_MAX : int'(sponge_reg);
    cur  = p.flush ? 0 : longint'($signed(p.cur));
    prev = p.flush ? 0 : longint'($signed(p.prev));
    vel  = p.flush ? 32'd0 : p.vel;
    if (row_pos >= rows) begin
      row_pos = 0;
      col_pos++;
    end
    if (col_pos >= cols + 2) col_pos = 0;
    c = col_pos;
    r = row_pos;
    dslot = (c % 2) * awst_pkg::ROWS_MAX + r;
    if (c >= 2) begin
      ox = c - 2;
      oz = r;
      flag = 1'b0;
      center = cur_at(ox, oz);
      p_old = longint'($signed(prev_line[dslot]));
      if (ox >= 2 && ox < cols - 2 && oz >= 2 && oz < rows - 2) begin
        // x neighbours: slot ox+3 holds column ox-1, the input column is ox+2
        lap = tap(kz_near, cur_at(ox, oz - 1)) + tap(kz_near, cur_at(ox, oz + 1))
            + tap(kz_far, cur_at(ox, oz - 2)) + tap(kz_far, cur_at(ox, oz + 2))
            + tap(kx_near, cur_at(ox + 3, oz)) + tap(kx_near, cur_at(ox + 1, oz))
            + tap(kx_far, cur_at(ox + 2, oz)) + tap(kx_far, cur)
            - 2 * (tap(kz_near, center) + tap(kz_far, center)
                 + tap(kx_near, center) + tap(kx_far, center));
        lap = clip32(lap, flag);
        nxt = 2 * center - p_old
            + ((longint'(vel_line[dslot]) * lap) >>> awst_pkg::FRAC_BITS);
        nxt = clip32(nxt, flag);
      end else begin
        nxt = p_old;
      end
      u.next_val = 32'(sponge(nxt, ox, oz, rows, cols, nb));
      u.damped   = 32'(sponge(center, ox, oz, rows, cols, nb));
      u.last     = (ox == cols - 1 && oz == rows - 1);
      u.sat      = flag;
      expected_updates.push_back(u);
    end
    cur_mem[(c % 4) * awst_pkg::ROWS_MAX + r] = 32'(cur);
    prev_line[dslot] = 32'(prev);
    vel_line[dslot] = vel;
    row_pos = r + 1;
    if (row_pos >= rows) begin
      row_pos = 0;
      col_pos = c + 1;
      if (col_pos >= cols + 2) col_pos = 0;
    end
  endfunction

  // ---------------- sender: bursts and gaps ----------------
  int burst_left = 0;
  int gap_left = 0;

  always @(posedge clk) begin
    point_t p;
    if (rst) begin
      samples_if.valid <= 1'b0;
    end else if (!samples_if.valid || samples_if.ready) begin
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        samples_if.valid <= 1'b0;
      end else if (pending_points.size() > 0) begin
        p = pending_points.pop_front();
        samples_if.valid      <= 1'b1;
        samples_if.cur_value  <= p.cur;
        samples_if.prev_value <= p.prev;
        samples_if.vel_term   <= p.vel;
        samples_if.flush      <= p.flush;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 48);
          gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        samples_if.valid <= 1'b0;
      end
    end
  end

  // predict on each accepted input beat
  always @(posedge clk) begin
    point_t p;
    if (!rst && samples_if.valid && samples_if.ready) begin
      p.cur   = samples_if.cur_value;
      p.prev  = samples_if.prev_value;
      p.vel   = samples_if.vel_term;
      p.flush = samples_if.flush;
      advance_stencil(p);
    end
  end

  // ---------------- receiver: stall pattern ----------------
  int stall_mode = 0;
  int cyc = 0;

  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (cyc % 97 == 0) stall_mode <= $urandom_range(0, 3);
    if (rst) results_if.ready <= 1'b0;
    else case (stall_mode)
      0:       results_if.ready <= 1'b1;
      1:       results_if.ready <= ($urandom_range(0, 3) != 0);
      2:       results_if.ready <= ((cyc % 8) < 5);
      default: results_if.ready <= ($urandom_range(0, 3) == 0);
    endcase
  end

  // ---------------- monitor ----------------
  always @(posedge clk) begin
    update_t e;
    if (!rst && results_if.valid && results_if.ready) begin
      if (expected_updates.size() == 0) begin
        $error("result beat with nothing expected");
        failed = 1'b1;
      end else begin
        e = expected_updates.pop_front();
        if (results_if.next_value !== e.next_val) begin
          $error("next_value exp %h got %h", e.next_val, results_if.next_value);
          failed = 1'b1;
        end
        if (results_if.damped_current !== e.damped) begin
          $error("damped_current exp %h got %h", e.damped, results_if.damped_current);
          failed = 1'b1;
        end
        if (results_if.last_of_frame !== e.last) begin
          $error("last_of_frame exp %b got %b", e.last, results_if.last_of_frame);
          failed = 1'b1;
        end
        if (results_if.saturated !== e.sat) begin
          $error("saturated exp %b got %b", e.sat, results_if.saturated);
          failed = 1'b1;
        end
      end
    end
  end

  // ---------------- stimulus ----------------
  task automatic write_reg(awst_pkg::cfg_reg_t idx, logic [31:0] v);
    @(posedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= v;
    do @(posedge clk); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    case (idx)
      awst_pkg::REG_COEF_Z_NEAR:  kz_near = longint'($signed(v));
      awst_pkg::REG_COEF_Z_FAR:   kz_far  = longint'($signed(v));
      awst_pkg::REG_COEF_X_NEAR:  kx_near = longint'($signed(v));
      awst_pkg::REG_COEF_X_FAR:   kx_far  = longint'($signed(v));
      awst_pkg::REG_ROWS_USED:    rows_reg = v[9:0];
      awst_pkg::REG_COLS_USED:    cols_reg = v[10:0];
      awst_pkg::REG_SPONGE_CELLS: sponge_reg = v[6:0];
      default: ;
    endcase
  endtask

  function automatic logic [31:0] scaled_word();
    logic [31:0] v;
    v = $urandom;
    case ($urandom_range(0, 7))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2, 3:    return v;
      default: return 32'($signed(v) >>> $urandom_range(8, 31));
    endcase
  endfunction

  function automatic logic [31:0] scaled_vel();
    case ($urandom_range(0, 5))
      0:       return 32'hFFFF_FFFF;
      1:       return $urandom;
      default: return $urandom >> $urandom_range(12, 31);
    endcase
  endfunction

  // one full frame: cols+2 columns, the last two drain the lag
  task automatic queue_frame(int flush_pct, int drain_data_pct);
    int rows, cols;
    point_t p;
    rows = rows_eff();
    cols = cols_eff();
    for (int c = 0; c < cols + 2; c++)
      for (int r = 0; r < rows; r++) begin
        p.cur = scaled_word();
        p.prev = scaled_word();
        p.vel = scaled_vel();
        if (c >= cols) p.flush = ($urandom_range(0, 99) >= drain_data_pct);
        else p.flush = ($urandom_range(0, 99) < flush_pct);
        pending_points.push_back(p);
      end
  endtask

  task automatic drain();
    while (pending_points.size() > 0 || samples_if.valid || expected_updates.size() > 0)
      @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic random_coefs();
    write_reg(awst_pkg::REG_COEF_Z_NEAR, scaled_word());
    write_reg(awst_pkg::REG_COEF_Z_FAR, scaled_word());
    write_reg(awst_pkg::REG_COEF_X_NEAR, scaled_word());
    write_reg(awst_pkg::REG_COEF_X_FAR, scaled_word());
  endtask

  initial begin
    int sent;
    int rows, cols;
    samples_if.valid = 1'b0;
    samples_if.cur_value = '0;
    samples_if.prev_value = '0;
    samples_if.vel_term = '0;
    samples_if.flush = 1'b0;
    results_if.ready = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.index = awst_pkg::REG_COEF_Z_NEAR;
    cfg_if.data = '0;
    kz_near = 0; kz_far = 0; kx_near = 0; kx_far = 0;
    rows_reg = 10'd5; cols_reg = 11'd5; sponge_reg = 7'd0;
    row_pos = 0; col_pos = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // directed: reset settings, then extreme coefficients and an
    // oversized sponge over a minimal grid, flushes and drain data
    queue_frame(0, 0);
    drain();
    write_reg(awst_pkg::REG_COEF_Z_NEAR, 32'h7FFF_FFFF);
    write_reg(awst_pkg::REG_COEF_Z_FAR, 32'h8000_0000);
    write_reg(awst_pkg::REG_COEF_X_NEAR, 32'h0155_5555);
    write_reg(awst_pkg::REG_COEF_X_FAR, 32'hFFEA_AAAB);
    write_reg(awst_pkg::REG_ROWS_USED, 32'd0);
    write_reg(awst_pkg::REG_COLS_USED, 32'd3);
    write_reg(awst_pkg::REG_SPONGE_CELLS, 32'd127);
    queue_frame(20, 50);
    drain();

    // tall grid under a full-width sponge, then a wide grid with a narrow one
    write_reg(awst_pkg::REG_ROWS_USED, 32'd20);
    write_reg(awst_pkg::REG_COLS_USED, 32'd5);
    write_reg(awst_pkg::REG_SPONGE_CELLS, 32'd64);
    random_coefs();
    queue_frame(5, 30);
    drain();
    write_reg(awst_pkg::REG_ROWS_USED, 32'd5);
    write_reg(awst_pkg::REG_COLS_USED, 32'd24);
    write_reg(awst_pkg::REG_SPONGE_CELLS, 32'd1);
    queue_frame(5, 30);
    drain();

    // random frames, mostly small
    sent = 0;
    while (sent < 120) begin
      random_coefs();
      write_reg(awst_pkg::REG_ROWS_USED, $urandom_range(0, 14));
      write_reg(awst_pkg::REG_COLS_USED, $urandom_range(0, 12));
      write_reg(awst_pkg::REG_SPONGE_CELLS, ($urandom_range(0, 4) == 0) ?
                                            $urandom_range(0, 127) : $urandom_range(0, 4));
      rows = rows_eff();
      cols = cols_eff();
      repeat ($urandom_range(1, 2)) begin
        queue_frame($urandom_range(0, 10), $urandom_range(0, 30));
        sent += rows * (cols + 2);
      end
      drain();
    end

    if (!failed) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

  initial begin
    #20ms;
    $display("TEST FAILED");
    $finish;
  end

endmodule

/* sim.f */
hdl/awst_pkg.sv
hdl/awst_ifs.sv
hdl/acoustic_wave_stencil_step_core.sv
hdl/awst_checker.sv
tb/sv/acoustic_wave_stencil_step_core_test.sv
